// ===== rtl/core/sdfd_pkg.sv =====
// Shared constants and types for the signed decimal fraction divider.
// No dependencies; used by every file in rtl/core.
`timescale 1ns / 1ps
package sdfd_pkg;

  localparam int unsigned MaxPlaces = 9;
  localparam logic [31:0] QMax      = 32'h7FFF_FFFF;
  localparam logic [31:0] DivLimit  = 32'h7FFF_FFFF / 32'd10;

  // Integer stage count: 33 quotient bits, one bit per stage.
  localparam int unsigned IntSteps  = 33;
  localparam int unsigned StageCnt  = IntSteps + MaxPlaces;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_TOO_BIG  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  // Item state carried down the pipeline.
  typedef struct packed {
    logic [32:0] num;    // dividend bits still to shift in
    logic [28:0] den;    // divisor magnitude, below DivLimit
    logic [28:0] rem;    // partial remainder
    logic [32:0] quo;    // quotient magnitude, saturating at QMax + 1
    logic        ovf;
    logic        neg;
    logic [3:0]  places;
    status_e     status; // early status for zero or oversized divisor
  } item_t;

endpackage

// ===== rtl/core/sdfd_int_step.sv =====
// One restoring-division stage for the integer part of the quotient.
// Depends on sdfd_pkg.
`timescale 1ns / 1ps
module sdfd_int_step (
  input  sdfd_pkg::item_t item_i,
  output sdfd_pkg::item_t item_o
);

  logic [29:0] trial;
  logic [29:0] diff;

  // Shift in the next dividend bit and try to subtract the divisor.
  always_comb begin
    item_o = item_i;
    trial  = {item_i.rem, item_i.num[32]};
    diff   = trial - {1'b0, item_i.den};
    item_o.num = {item_i.num[31:0], 1'b0};
    if (!diff[29]) begin
      item_o.rem = diff[28:0];
      item_o.quo = {item_i.quo[31:0], 1'b1};
    end else begin
      item_o.rem = trial[28:0];
      item_o.quo = {item_i.quo[31:0], 1'b0};
    end
  end

endmodule

// ===== rtl/core/sdfd_dec_step.sv =====
// One decimal digit stage: ten times the remainder divided by the divisor.
// Depends on sdfd_pkg. Digit found by a compare against nine multiples.
`timescale 1ns / 1ps
module sdfd_dec_step (
  input  logic [3:0]      place_idx_i,
  input  sdfd_pkg::item_t item_i,
  output sdfd_pkg::item_t item_o
);

  logic [32:0] t;
  logic [32:0] mult;
  logic [3:0]  digit;
  logic [36:0] qx;

  // Pick the largest multiple of the divisor that fits, then scale quotient.
  always_comb begin
    item_o = item_i;
    t      = {1'b0, item_i.rem, 3'b000} + {3'b000, item_i.rem, 1'b0};
    digit  = 4'd0;
    mult   = 33'd0;
    for (int k = 1; k < 10; k++) begin
      if (t >= 33'(k) * {4'd0, item_i.den}) begin
        digit = 4'(k);
        mult  = 33'(k) * {4'd0, item_i.den};
      end
    end
    qx = {1'b0, item_i.quo, 3'b000} + {3'b000, item_i.quo, 1'b0} + {33'd0, digit};
    if (place_idx_i < item_i.places) begin
      item_o.rem = 29'(t - mult);
      if (qx > {5'd0, sdfd_pkg::QMax}) begin
        item_o.ovf = 1'b1;
        item_o.quo = {1'b0, sdfd_pkg::QMax} + 33'd1;
      end else begin
        item_o.quo = qx[32:0];
      end
    end
  end

endmodule

// ===== rtl/core/signed_decimal_fraction_divider.sv =====
// Top level of the signed decimal fraction divider: a stall-safe pipeline.
// Depends on sdfd_pkg, sdfd_int_step and sdfd_dec_step.
//
//  channel | dir | tdata fields (low bit up)               | tuser
//  s_axis  | in  | dividend[31:0] divisor[63:32] places[67:64] | -
//  m_axis  | out | quotient[31:0] status[33:32]             | -
//
// There are 44 register stages: one input stage, 33 integer bit stages, nine
// decimal stages and the rounding output stage. One item may enter every
// cycle while m_axis is not stalled.
// Reset clears all valid bits. A stall on m_axis freezes the whole pipeline
// in place, so nothing is lost or repeated.
`timescale 1ns / 1ps
module signed_decimal_fraction_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // dividend, divisor, places, zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // quotient, status, zero pad
);

  logic             adv;
  sdfd_pkg::item_t  in_item;
  sdfd_pkg::item_t  stg_q   [sdfd_pkg::StageCnt+1];
  logic             vld_q   [sdfd_pkg::StageCnt+1];
  sdfd_pkg::item_t  stg_nx  [sdfd_pkg::StageCnt];
  sdfd_pkg::item_t  int_done;
  logic [31:0]      quo_q;
  logic [1:0]       st_q;
  logic             out_vld_q;

  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;

  // Magnitudes, combined sign and early checks for the incoming request.
  logic [31:0] dvd, dvs;
  logic [32:0] num_m, den_m;
  always_comb begin
    dvd = s_axis_tdata[31:0];
    dvs = s_axis_tdata[63:32];
    num_m = dvd[31] ? 33'h1_0000_0000 - {1'b0, dvd} : {1'b0, dvd};
    den_m = dvs[31] ? 33'h1_0000_0000 - {1'b0, dvs} : {1'b0, dvs};
    in_item = '0;
    in_item.num = num_m;
    in_item.den = den_m[28:0];
    in_item.neg = dvd[31] ^ dvs[31];
    in_item.places = (s_axis_tdata[67:64] > 4'(sdfd_pkg::MaxPlaces)) ?
                     4'(sdfd_pkg::MaxPlaces) : s_axis_tdata[67:64];
    if (den_m == 33'd0) begin
      in_item.status = sdfd_pkg::ST_DIV_ZERO;
    end else if (den_m >= {1'b0, sdfd_pkg::DivLimit}) begin
      in_item.status = sdfd_pkg::ST_TOO_BIG;
    end else begin
      in_item.status = sdfd_pkg::ST_OK;
    end
    // Oversized divisors would not fit the remainder, and a zero divisor is unusable: clamp both harmlessly.
    if (in_item.status != sdfd_pkg::ST_OK) begin
      in_item.den = 29'd1;
    end
  end

  // Integer quotient above QMax saturates before the decimal stages.
  always_comb begin
    int_done = stg_q[sdfd_pkg::IntSteps];
    if (int_done.quo > {1'b0, sdfd_pkg::QMax}) begin
      int_done.ovf = 1'b1;
      int_done.quo = {1'b0, sdfd_pkg::QMax} + 33'd1;
    end
  end

  // Stage logic between registers.
  for (genvar g = 0; g < sdfd_pkg::StageCnt; g++) begin : g_stage
    if (g < sdfd_pkg::IntSteps) begin : g_int
      sdfd_int_step u_int (.item_i(stg_q[g]), .item_o(stg_nx[g]));
    end else if (g == sdfd_pkg::IntSteps) begin : g_dec_first
      sdfd_dec_step u_dec (
        .place_idx_i(4'd0),
        .item_i     (int_done),
        .item_o     (stg_nx[g])
      );
    end else begin : g_dec
      sdfd_dec_step u_dec (
        .place_idx_i(4'(g - sdfd_pkg::IntSteps)),
        .item_i     (stg_q[g]),
        .item_o     (stg_nx[g])
      );
    end
  end

  // Pipeline registers; valid bits reset, payload does not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= sdfd_pkg::StageCnt; i++) vld_q[i] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= s_axis_tvalid;
      for (int i = 1; i <= sdfd_pkg::StageCnt; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      stg_q[0] <= in_item;
      for (int i = 1; i <= sdfd_pkg::StageCnt; i++) begin
        stg_q[i] <= stg_nx[i-1];
      end
    end
  end

  // Rounding, sign and status on the last stage.
  logic [33:0] rq;
  logic [31:0] mag;
  logic        ovf_f;
  sdfd_pkg::item_t fin;
  always_comb begin
    fin   = stg_q[sdfd_pkg::StageCnt];
    rq    = {1'b0, fin.quo} + {33'd0, ({fin.rem, 1'b0} >= {1'b0, fin.den})};
    ovf_f = fin.ovf;
    if (rq > {2'b0, sdfd_pkg::QMax}) begin
      ovf_f = 1'b1;
      mag   = sdfd_pkg::QMax;
    end else begin
      mag = rq[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      quo_q     <= '0;
      st_q      <= '0;
    end else if (adv) begin
      out_vld_q <= vld_q[sdfd_pkg::StageCnt];
      if (fin.status != sdfd_pkg::ST_OK) begin
        quo_q <= '0;
        st_q  <= fin.status;
      end else begin
        quo_q <= fin.neg ? 32'd0 - mag : mag;
        st_q  <= ovf_f ? sdfd_pkg::ST_OVERFLOW : sdfd_pkg::ST_OK;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'd0, st_q, quo_q};

`ifndef SYNTH
  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed under stall");
  // Error statuses always carry a zero quotient.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (st_q == sdfd_pkg::ST_DIV_ZERO || st_q == sdfd_pkg::ST_TOO_BIG)
    |-> quo_q == 32'd0)
    else $error("nonzero quotient with error status");
  // Ready follows output backpressure.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while pipeline stalled");
`endif

endmodule
